### sv/ubc_pkg.sv
package ubc_pkg;

    localparam int LENGTH_WIDTH = 16;
    localparam int INDEX_WIDTH  = 14;
    localparam int ADDR_WIDTH   = 4;
    localparam int DATA_WIDTH   = 32;

    localparam int FIFO_DEPTH   = 4;
    localparam int PTR_WIDTH    = $clog2(FIFO_DEPTH);
    localparam int CNT_WIDTH    = $clog2(FIFO_DEPTH + 1);

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_SRC_OFFSET = 2'd0;
    localparam logic [1:0] REG_DST_OFFSET = 2'd1;
    localparam logic [1:0] REG_LENGTH     = 2'd2;

    typedef struct packed {
        logic [7:0]             dst_byte;
        logic [7:0]             write_mask;
        logic [INDEX_WIDTH-1:0] dst_index;
        logic                   last;
    } result_t;

    typedef struct packed {
        logic [7:0]              pending_bits;
        logic [7:0]              pending_mask;
        logic [2:0]              pending_count;
        logic [LENGTH_WIDTH-1:0] bits_left;
        logic [INDEX_WIDTH-1:0]  out_position;
        logic                    first_source;
    } state_t;

    typedef struct packed {
        logic [1:0] num;
        result_t    slot_a;
        result_t    slot_b;
        state_t     next;
    } step_t;

endpackage

### sv/ubc_align.sv
module ubc_align
    import ubc_pkg::*;
(
    input  logic [2:0] first_skip,
    input  logic [7:0] src_byte,
    input  state_t     st,
    output step_t      step
);

    logic [2:0]              skip;
    logic [3:0]              n_full;
    logic [3:0]              n;
    logic [7:0]              topn;
    logic [7:0]              v;
    logic [15:0]             acc;
    logic [15:0]             msk;
    logic [15:0]             acc2;
    logic [15:0]             msk2;
    logic [3:0]              total;
    logic [3:0]              total2;
    logic [LENGTH_WIDTH-1:0] bl_new;
    logic                    active;
    logic                    e0;
    logic                    e1;
    result_t                 r0;
    result_t                 r1;

    always_comb
    begin
        skip   = st.first_source ? first_skip : 3'd0;
        n_full = 4'd8 - {1'b0, skip};
        if (LENGTH_WIDTH'(n_full) > st.bits_left)
            n = st.bits_left[3:0];
        else
            n = n_full;

        topn   = ~(8'hff >> n);
        v      = (src_byte << skip) & topn;
        acc    = {st.pending_bits, 8'h00} | ({v, 8'h00} >> st.pending_count);
        msk    = {st.pending_mask, 8'h00} | ({topn, 8'h00} >> st.pending_count);
        total  = {1'b0, st.pending_count} + n;
        bl_new = st.bits_left - LENGTH_WIDTH'(n);
        active = (st.bits_left != '0);

        // a full destination byte
        e0     = active && total[3];
        acc2   = e0 ? {acc[7:0], 8'h00} : acc;
        msk2   = e0 ? {msk[7:0], 8'h00} : msk;
        total2 = e0 ? {1'b0, total[2:0]} : total;
        // partial tail flushed at end of run
        e1     = active && (bl_new == '0) && (total2 != 4'd0);

        r0.dst_byte   = acc[15:8];
        r0.write_mask = msk[15:8];
        r0.dst_index  = st.out_position;
        r0.last       = (bl_new == '0) && (total == 4'd8);

        r1.dst_byte   = acc2[15:8];
        r1.write_mask = msk2[15:8];
        r1.dst_index  = e0 ? st.out_position + INDEX_WIDTH'(1) : st.out_position;
        r1.last       = 1'b1;

        step.num    = {1'b0, e0} + {1'b0, e1};
        step.slot_a = e0 ? r0 : r1;
        step.slot_b = r1;

        step.next = st;
        if (active)
        begin
            step.next.pending_bits  = e1 ? 8'h00 : acc2[15:8];
            step.next.pending_mask  = e1 ? 8'h00 : msk2[15:8];
            step.next.pending_count = e1 ? 3'd0 : total2[2:0];
            step.next.bits_left     = bl_new;
            step.next.out_position  = st.out_position + INDEX_WIDTH'(step.num);
            step.next.first_source  = 1'b0;
        end
    end

endmodule

### sv/ubc_fifo.sv
module ubc_fifo
    import ubc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_num,
    input  result_t    push_a,
    input  result_t    push_b,
    output logic       room,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    out_data
);

    result_t                mem_reg [FIFO_DEPTH];
    logic [PTR_WIDTH-1:0]   wr_ptr_reg;
    logic [PTR_WIDTH-1:0]   rd_ptr_reg;
    logic [CNT_WIDTH-1:0]   count_reg;
    logic [PTR_WIDTH-1:0]   wr_ptr_next;
    logic [PTR_WIDTH-1:0]   rd_ptr_next;
    logic [CNT_WIDTH-1:0]   count_next;
    logic                   pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    // room for two results, the most one transaction can produce
    assign room      = (count_reg <= CNT_WIDTH'(FIFO_DEPTH - 2));
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_WIDTH'(push_num);
        rd_ptr_next = rd_ptr_reg + PTR_WIDTH'(pop);
        count_next  = count_reg + CNT_WIDTH'(push_num) - CNT_WIDTH'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_num != 2'd0)
            mem_reg[wr_ptr_reg] <= push_a;
        if (push_num == 2'd2)
            mem_reg[wr_ptr_reg + PTR_WIDTH'(1)] <= push_b;
    end

endmodule

### sv/unaligned_bit_copy.sv
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+------------------------------------------
// source   | in        | in_valid / in_ready  | src_byte
// result   | out       | out_valid / out_ready| dst_byte, write_mask, dst_index, last
// config   | in        | APB (pready tied 1)  | src_bit_offset, dst_bit_offset, bit_length
//
// One source byte per cycle while in_ready is high; its results enter a 4-entry result queue
// at the accepting edge and can leave on the next edge.
// The final byte of a job may give two results; all others give at most one.
// in_ready drops only when the queue holds more than two results (output stalled).
// Reset is asynchronous and leaves no job active; any register write restarts the job.
module unaligned_bit_copy
    import ubc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_WIDTH-1:0]  paddr,
    input  logic [DATA_WIDTH-1:0]  pwdata,
    output logic [DATA_WIDTH-1:0]  prdata,
    output logic                   pready,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             src_byte,

    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             dst_byte,
    output logic [7:0]             write_mask,
    output logic [INDEX_WIDTH-1:0] dst_index,
    output logic                   last
);

    logic [2:0]              src_offset_reg;
    logic [2:0]              dst_offset_reg;
    logic [LENGTH_WIDTH-1:0] length_reg;
    state_t                  state_reg;
    state_t                  state_next;
    step_t                   step;
    result_t                 head;
    logic [1:0]              reg_index;
    logic                    cfg_write;
    logic                    cfg_hit;
    logic                    in_fire;
    logic                    room;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;
    assign cfg_hit   = cfg_write && (reg_index == REG_SRC_OFFSET ||
                                     reg_index == REG_DST_OFFSET ||
                                     reg_index == REG_LENGTH);
    assign in_ready  = room;
    assign in_fire   = in_valid && in_ready;

    always_comb
    begin
        unique case (reg_index)
            REG_SRC_OFFSET: prdata = DATA_WIDTH'(src_offset_reg);
            REG_DST_OFFSET: prdata = DATA_WIDTH'(dst_offset_reg);
            REG_LENGTH:     prdata = DATA_WIDTH'(length_reg);
            default:        prdata = '0;
        endcase
    end

    ubc_align u_align (
        .first_skip (src_offset_reg),
        .src_byte   (src_byte),
        .st         (state_reg),
        .step       (step)
    );

    always_comb
    begin
        state_next = state_reg;
        if (cfg_hit)
        begin
            state_next.pending_bits  = 8'h00;
            state_next.pending_mask  = 8'h00;
            state_next.pending_count = (reg_index == REG_DST_OFFSET) ? pwdata[2:0]
                                                                     : dst_offset_reg;
            state_next.bits_left     = (reg_index == REG_LENGTH) ? pwdata[LENGTH_WIDTH-1:0]
                                                                 : length_reg;
            state_next.out_position  = '0;
            state_next.first_source  = 1'b1;
        end
        else if (in_fire)
            state_next = step.next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_offset_reg           <= 3'd0;
            dst_offset_reg           <= 3'd0;
            length_reg               <= '0;
            state_reg.pending_bits   <= 8'h00;
            state_reg.pending_mask   <= 8'h00;
            state_reg.pending_count  <= 3'd0;
            state_reg.bits_left      <= '0;
            state_reg.out_position   <= '0;
            state_reg.first_source   <= 1'b1;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (reg_index)
                    REG_SRC_OFFSET: src_offset_reg <= pwdata[2:0];
                    REG_DST_OFFSET: dst_offset_reg <= pwdata[2:0];
                    REG_LENGTH:     length_reg     <= pwdata[LENGTH_WIDTH-1:0];
                    default:        ;
                endcase
            end
            state_reg <= state_next;
        end
    end

    ubc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_num  (in_fire && !cfg_hit ? step.num : 2'd0),
        .push_a    (step.slot_a),
        .push_b    (step.slot_b),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (head)
    );

    assign dst_byte   = head.dst_byte;
    assign write_mask = head.write_mask;
    assign dst_index  = head.dst_index;
    assign last       = head.last;

endmodule

### sv/ubc_checker.sv
module ubc_checker
    import ubc_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [7:0]             dst_byte,
    input logic [7:0]             write_mask,
    input logic [INDEX_WIDTH-1:0] dst_index,
    input logic                   last
);

    // a stalled result transaction holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(dst_byte) && $stable(write_mask)
                                    && $stable(dst_index) && $stable(last))
    else $error("result changed while stalled");

    // every result writes at least one bit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> write_mask != 8'h00)
    else $error("empty write mask");

    // unmasked data bits are zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (dst_byte & ~write_mask) == 8'h00)
    else $error("data outside write mask");

    // queue is empty once reset has been seen
    assert property (@(posedge clk)
        !rst_n |=> !out_valid)
    else $error("result valid in reset");

endmodule

bind unaligned_bit_copy ubc_checker u_ubc_checker (.*);
